### hdl/keyboard_poll_link_controller_defines.svh
// ----------------------------------------------------------------------------
// keyboard poll link controller assertion macros
// shared concurrent assertion forms, clocked on clk and disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef KEYBOARD_POLL_LINK_CONTROLLER_DEFINES_SVH
`define KEYBOARD_POLL_LINK_CONTROLLER_DEFINES_SVH

// same-cycle implication
`define KPLC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define KPLC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/kplc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kplc_pkg
// types and constants of the keyboard poll link controller
// ----------------------------------------------------------------------------
package kplc_pkg;

  // event kinds on the input channel
  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_IRQ  = 1'b1;

  // configuration register indexes
  localparam logic [2:0] REG_INQUIRY = 3'd0;
  localparam logic [2:0] REG_INSTANT = 3'd1;
  localparam logic [2:0] REG_MODEL   = 3'd2;
  localparam logic [2:0] REG_TEST    = 3'd3;
  localparam logic [2:0] REG_NULL    = 3'd4;
  localparam logic [2:0] REG_ACK     = 3'd5;
  localparam logic [2:0] REG_NACK    = 3'd6;
  localparam logic [2:0] REG_TIMEOUT = 3'd7;

  // configuration reset values
  localparam logic [7:0] RST_INQUIRY = 8'd16;
  localparam logic [7:0] RST_INSTANT = 8'd20;
  localparam logic [7:0] RST_MODEL   = 8'd22;
  localparam logic [7:0] RST_TEST    = 8'd54;
  localparam logic [7:0] RST_NULL    = 8'd123;
  localparam logic [7:0] RST_ACK     = 8'd125;
  localparam logic [7:0] RST_NACK    = 8'd119;
  localparam logic [7:0] RST_TIMEOUT = 8'd30;

  // line turnaround phases
  localparam logic [1:0] PHASE_SENT = 2'd0;
  localparam logic [1:0] PHASE_RECV = 2'd1;
  localparam logic [1:0] PHASE_DONE = 2'd2;

  // key decoding
  localparam logic [5:0] CAPS_KEY    = 6'h39;
  localparam logic [7:0] RELEASE_BIT = 8'h80;

  localparam logic [2:0] INIT_DELAY  = 3'd5;
  localparam logic [3:0] MAX_RETRIES = 4'd10;
  localparam logic [7:0] IDLE_MAX    = 8'd255;

  // self test outcome
  localparam logic [1:0] TEST_NONE = 2'd0;
  localparam logic [1:0] TEST_PASS = 2'd1;
  localparam logic [1:0] TEST_FAIL = 2'd2;

  // event codes
  localparam logic [1:0] EV_NONE    = 2'd0;
  localparam logic [1:0] EV_LOST    = 2'd1;
  localparam logic [1:0] EV_UNKNOWN = 2'd2;
  localparam logic [1:0] EV_REINIT  = 2'd3;

  typedef struct packed {
    logic       send_valid;
    logic [7:0] send_byte;
    logic       to_receive;
    logic       key_valid;
    logic [7:0] key_code;
    logic       last;
    logic [1:0] test_result;
    logic [2:0] kbd_model;
    logic [2:0] kbd_next;
    logic       next_chained;
    logic       ready_res;
    logic [1:0] event_res;
  } res_t;

endpackage

### hdl/kplc_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kplc_in_if / kplc_out_if
// valid/ready channels for link events and link results
// ----------------------------------------------------------------------------
interface kplc_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] rx_byte;

  modport source (output valid, output cmd, output rx_byte, input ready);
  modport sink   (input valid, input cmd, input rx_byte, output ready);
endinterface

interface kplc_out_if import kplc_pkg::*; ();
  logic valid;
  logic ready;
  res_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### hdl/keyboard_poll_link_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyboard_poll_link_controller
// host side of a polled serial keyboard link
// ----------------------------------------------------------------------------
// One event (timer tick or shift-complete interrupt) is taken per clock and
// fully processed in that cycle; its results go into a four-entry result
// queue. Every event gives one result except a caps lock transition, which
// gives a press and then a release. The input is ready whenever the queue has
// at least two free entries; with the output drained every cycle the block
// takes one event per clock until caps lock pairs fill the queue. Configuration
// must be written through the cfg_ port only while idle; this is not enforced.
// ----------------------------------------------------------------------------
`include "keyboard_poll_link_controller_defines.svh"

module keyboard_poll_link_controller import kplc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [2:0]       cfg_index,
  input  logic [7:0]       cfg_data,
  kplc_in_if.sink          in_ch,
  kplc_out_if.source       out_ch
);

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  // configuration registers
  logic [7:0] inquiry_r, instant_r, model_code_r, test_r;
  logic [7:0] null_r, ack_r, nack_r, timeout_r;

  // link state
  logic [7:0] sent_r, sent_nxt;
  logic [1:0] phase_r, phase_nxt;
  logic [7:0] queued_r, queued_nxt;
  logic       qvalid_r, qvalid_nxt;
  logic [2:0] delay_r, delay_nxt;
  logic [7:0] idle_r, idle_nxt;
  logic [3:0] retry_r, retry_nxt;
  logic [2:0] model_r, model_nxt;
  logic [2:0] next_model_r, next_model_nxt;
  logic       chained_r, chained_nxt;
  logic       init_r, init_nxt;

  // result queue
  res_t              fifo_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;

  logic       in_acc, out_acc, two_res;
  logic [7:0] idle_inc;
  logic [3:0] retry_inc;
  logic [5:0] key_num;
  logic       is_key_cmd;
  res_t       res0, res1;

  assign in_acc  = in_ch.valid && in_ch.ready;
  assign out_acc = out_ch.valid && out_ch.ready;

  assign idle_inc   = (idle_r < IDLE_MAX) ? idle_r + 8'd1 : idle_r;
  assign retry_inc  = retry_r + 4'd1;
  assign key_num    = in_ch.rx_byte[6:1];
  assign is_key_cmd = (sent_r == inquiry_r) || (sent_r == instant_r);

  always_comb begin
    sent_nxt       = sent_r;
    phase_nxt      = phase_r;
    queued_nxt     = queued_r;
    qvalid_nxt     = qvalid_r;
    delay_nxt      = delay_r;
    idle_nxt       = idle_r;
    retry_nxt      = retry_r;
    model_nxt      = model_r;
    next_model_nxt = next_model_r;
    chained_nxt    = chained_r;
    init_nxt       = init_r;
    two_res        = 1'b0;
    res0           = '0;
    res0.last      = 1'b1;

    if (in_ch.cmd == CMD_TICK) begin
      if (delay_r != 3'd0) begin
        delay_nxt = delay_r - 3'd1;
      end else if (qvalid_r) begin
        qvalid_nxt      = 1'b0;
        res0.send_valid = 1'b1;
        res0.send_byte  = queued_r;
        sent_nxt        = queued_r;
        phase_nxt       = PHASE_SENT;
      end
      idle_nxt = idle_inc;
      if (idle_inc > timeout_r) begin
        if (retry_inc > MAX_RETRIES) begin
          res0.event_res = EV_LOST;
          retry_nxt      = 4'd0;
        end else begin
          retry_nxt = retry_inc;
        end
        init_nxt   = 1'b0;
        idle_nxt   = 8'd0;
        delay_nxt  = INIT_DELAY;
        queued_nxt = model_code_r;
        qvalid_nxt = 1'b1;
      end
    end else if (phase_r == PHASE_SENT) begin
      res0.to_receive = 1'b1;
      phase_nxt       = PHASE_RECV;
    end else if (phase_r == PHASE_RECV) begin
      idle_nxt  = 8'd0;
      phase_nxt = PHASE_DONE;
      retry_nxt = 4'd0;
      priority if (is_key_cmd) begin
        queued_nxt = inquiry_r;
        qvalid_nxt = 1'b1;
        if (in_ch.rx_byte != null_r) begin
          res0.key_valid = 1'b1;
          if (key_num == CAPS_KEY) begin
            // caps lock reports only its state: fake a press then a release
            two_res       = 1'b1;
            res0.key_code = {2'b00, CAPS_KEY};
            res0.last     = 1'b0;
          end else begin
            res0.key_code = {in_ch.rx_byte[7], 1'b0, key_num};
          end
        end
      end else if (sent_r == model_code_r) begin
        if (in_ch.rx_byte[0]) begin
          model_nxt      = in_ch.rx_byte[3:1];
          next_model_nxt = in_ch.rx_byte[6:4];
          chained_nxt    = in_ch.rx_byte[7];
          init_nxt       = 1'b1;
          delay_nxt      = INIT_DELAY;
          queued_nxt     = inquiry_r;
          qvalid_nxt     = 1'b1;
        end else begin
          res0.event_res = EV_REINIT;
          init_nxt       = 1'b0;
          idle_nxt       = 8'd0;
          delay_nxt      = INIT_DELAY;
          queued_nxt     = model_code_r;
          qvalid_nxt     = 1'b1;
        end
      end else if (sent_r == test_r) begin
        priority if (in_ch.rx_byte == ack_r) begin
          res0.test_result = TEST_PASS;
        end else if (in_ch.rx_byte == nack_r) begin
          res0.test_result = TEST_FAIL;
        end else begin
          res0.event_res = EV_REINIT;
          init_nxt       = 1'b0;
          idle_nxt       = 8'd0;
          delay_nxt      = INIT_DELAY;
          queued_nxt     = model_code_r;
          qvalid_nxt     = 1'b1;
        end
      end else begin
        res0.event_res = EV_UNKNOWN;
      end
    end

    res0.kbd_model    = model_nxt;
    res0.kbd_next     = next_model_nxt;
    res0.next_chained = chained_nxt;
    res0.ready_res    = init_nxt;

    res1          = res0;
    res1.key_code = RELEASE_BIT | {2'b00, CAPS_KEY};
    res1.last     = 1'b1;
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inquiry_r    <= RST_INQUIRY;
      instant_r    <= RST_INSTANT;
      model_code_r <= RST_MODEL;
      test_r       <= RST_TEST;
      null_r       <= RST_NULL;
      ack_r        <= RST_ACK;
      nack_r       <= RST_NACK;
      timeout_r    <= RST_TIMEOUT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_INQUIRY: inquiry_r    <= cfg_data;
        REG_INSTANT: instant_r    <= cfg_data;
        REG_MODEL:   model_code_r <= cfg_data;
        REG_TEST:    test_r       <= cfg_data;
        REG_NULL:    null_r       <= cfg_data;
        REG_ACK:     ack_r        <= cfg_data;
        REG_NACK:    nack_r       <= cfg_data;
        REG_TIMEOUT: timeout_r    <= cfg_data;
      endcase
    end
  end

  // link state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sent_r       <= 8'd0;
      phase_r      <= PHASE_SENT;
      queued_r     <= RST_MODEL;
      qvalid_r     <= 1'b1;
      delay_r      <= INIT_DELAY;
      idle_r       <= 8'd0;
      retry_r      <= 4'd0;
      model_r      <= 3'd0;
      next_model_r <= 3'd0;
      chained_r    <= 1'b0;
      init_r       <= 1'b0;
    end else if (in_acc) begin
      sent_r       <= sent_nxt;
      phase_r      <= phase_nxt;
      queued_r     <= queued_nxt;
      qvalid_r     <= qvalid_nxt;
      delay_r      <= delay_nxt;
      idle_r       <= idle_nxt;
      retry_r      <= retry_nxt;
      model_r      <= model_nxt;
      next_model_r <= next_model_nxt;
      chained_r    <= chained_nxt;
      init_r       <= init_nxt;
    end
  end

  // result queue storage
  always_ff @(posedge clk) begin
    if (in_acc) begin
      fifo_r[wr_ptr_r] <= res0;
      if (two_res) begin
        fifo_r[wr_ptr_r + QPTR_W'(1)] <= res1;
      end
    end
  end

  // result queue pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (in_acc) begin
        wr_ptr_r <= wr_ptr_r + (two_res ? QPTR_W'(2) : QPTR_W'(1));
      end
      if (out_acc) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      cnt_r <= cnt_r
             + (in_acc ? (two_res ? QCNT_W'(2) : QCNT_W'(1)) : QCNT_W'(0))
             - (out_acc ? QCNT_W'(1) : QCNT_W'(0));
    end
  end

  assign in_ch.ready  = (cnt_r <= QCNT_W'(QDEPTH - 2));
  assign out_ch.valid = (cnt_r != '0);
  assign out_ch.data  = fifo_r[rd_ptr_r];

  `KPLC_ASSERT_SAME(a_queue_bound, clk, rst_n, 1'b1, cnt_r <= QCNT_W'(QDEPTH),
                    "result queue overflow")
  `KPLC_ASSERT_SAME(a_accept_room, clk, rst_n, in_acc, cnt_r <= QCNT_W'(QDEPTH - 2),
                    "event taken without queue room")
  `KPLC_ASSERT_SAME(a_send_after_delay, clk, rst_n, in_acc && res0.send_valid,
                    delay_r == 3'd0 && qvalid_r, "command sent before delay expired")
  `KPLC_ASSERT_SAME(a_phase_range, clk, rst_n, 1'b1, phase_r != 2'd3,
                    "turnaround phase out of range")
  `KPLC_ASSERT_NEXT(a_caps_pair, clk, rst_n, in_acc && two_res,
                    fifo_r[$past(wr_ptr_r) + QPTR_W'(1)].last, "caps release not marked last")

endmodule

### tb/tb_keyboard_poll_link_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_keyboard_poll_link_controller
// self-checking bench for the polled keyboard link controller
// ----------------------------------------------------------------------------
// Link events go in through a valid/ready channel in bursts with random gaps,
// while the result channel stalls on its own pattern. A tracker class keeps
// its own copy of the link state and the command/reply codes. It predicts the
// results of every accepted event and checks each result field by field, in
// order. After a short directed sequence, most random traffic follows
// complete poll exchanges: ticks up to a send, then turnaround, then reply.
// The rest is noise and long tick runs that force timeouts and link loss.
// The code registers are rewritten between phases, including extremes and
// colliding codes. They are also retargeted in the middle of an exchange, so
// that test, instant and unknown replies get decoded.
// ----------------------------------------------------------------------------
module tb_keyboard_poll_link_controller;
  import kplc_pkg::*;

  localparam int STALL_LIMIT  = 2000;
  localparam int RANDOM_ITEMS = 1050;
  localparam int NUM_PHASES   = 8;
  localparam int LONG_RUN_MAX = 150;

  // ways to retarget the codes while a reply is outstanding
  localparam int AIM_TEST    = 0;
  localparam int AIM_INSTANT = 1;
  localparam int AIM_OTHER   = 2;

  class kbd_link_tracker;
    logic [7:0] regs [8];
    logic [7:0] sent_cmd;
    logic [1:0] phase;
    logic [7:0] queued_cmd;
    logic       queue_valid;
    logic [2:0] delay_cnt;
    logic [7:0] idle_cnt;
    logic [3:0] retries;
    logic [2:0] model_id;
    logic [2:0] next_id;
    logic       chained;
    logic       linked;
    logic       sent_now;
    res_t       expected_q [$];
    int         errors;

    function new();
      regs[REG_INQUIRY] = RST_INQUIRY;
      regs[REG_INSTANT] = RST_INSTANT;
      regs[REG_MODEL]   = RST_MODEL;
      regs[REG_TEST]    = RST_TEST;
      regs[REG_NULL]    = RST_NULL;
      regs[REG_ACK]     = RST_ACK;
      regs[REG_NACK]    = RST_NACK;
      regs[REG_TIMEOUT] = RST_TIMEOUT;
      sent_cmd    = '0;
      phase       = PHASE_SENT;
      queued_cmd  = RST_MODEL;
      queue_valid = 1'b1;
      delay_cnt   = INIT_DELAY;
      idle_cnt    = '0;
      retries     = '0;
      model_id    = '0;
      next_id     = '0;
      chained     = 1'b0;
      linked      = 1'b0;
      sent_now    = 1'b0;
      errors      = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [7:0] val);
      regs[idx] = val;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // drop the link and queue a model query again
    function void restart_link();
      linked      = 1'b0;
      idle_cnt    = '0;
      delay_cnt   = INIT_DELAY;
      queued_cmd  = regs[REG_MODEL];
      queue_valid = 1'b1;
    endfunction

    function void push_res(logic sv, logic [7:0] sb, logic tr, logic kv, logic [7:0] kc,
                           logic lst, logic [1:0] test, logic [1:0] ev);
      res_t r;
      r.send_valid   = sv;
      r.send_byte    = sb;
      r.to_receive   = tr;
      r.key_valid    = kv;
      r.key_code     = kc;
      r.last         = lst;
      r.test_result  = test;
      r.kbd_model    = model_id;
      r.kbd_next     = next_id;
      r.next_chained = chained;
      r.ready_res    = linked;
      r.event_res    = ev;
      expected_q.push_back(r);
    endfunction

    function void note_event(logic c, logic [7:0] rx);
      logic       sv;
      logic [7:0] sb;
      logic       tr;
      logic [1:0] test;
      logic [1:0] ev;
      logic [5:0] key;
      sv = 1'b0;
      sb = '0;
      tr = 1'b0;
      test = TEST_NONE;
      ev = EV_NONE;
      sent_now = 1'b0;
      if (c == CMD_TICK) begin
        if (delay_cnt != 0) begin
          delay_cnt = delay_cnt - 1'b1;
        end else if (queue_valid) begin
          queue_valid = 1'b0;
          sv = 1'b1;
          sb = queued_cmd;
          sent_cmd = queued_cmd;
          phase = PHASE_SENT;
          sent_now = 1'b1;
        end
        if (idle_cnt != IDLE_MAX) idle_cnt = idle_cnt + 1'b1;
        if (idle_cnt > regs[REG_TIMEOUT]) begin
          retries = retries + 1'b1;
          if (retries > MAX_RETRIES) begin
            ev = EV_LOST;
            retries = '0;
          end
          restart_link();
        end
        push_res(sv, sb, 1'b0, 1'b0, 8'h00, 1'b1, test, ev);
        return;
      end
      if (phase == PHASE_SENT) begin
        tr = 1'b1;
        phase = PHASE_RECV;
      end else if (phase == PHASE_RECV) begin
        idle_cnt = '0;
        phase = PHASE_DONE;
        retries = '0;
        if (sent_cmd == regs[REG_INQUIRY] || sent_cmd == regs[REG_INSTANT]) begin
          queued_cmd = regs[REG_INQUIRY];
          queue_valid = 1'b1;
          if (rx != regs[REG_NULL]) begin
            key = rx[6:1];
            // caps lock only reports its state, so it becomes a press and a release
            if (key == CAPS_KEY) begin
              push_res(1'b0, 8'h00, 1'b0, 1'b1, {2'b00, CAPS_KEY}, 1'b0, TEST_NONE, EV_NONE);
              push_res(1'b0, 8'h00, 1'b0, 1'b1, RELEASE_BIT | {2'b00, CAPS_KEY}, 1'b1,
                       TEST_NONE, EV_NONE);
              return;
            end
            push_res(1'b0, 8'h00, 1'b0, 1'b1, {rx[7], 1'b0, key}, 1'b1, TEST_NONE, EV_NONE);
            return;
          end
        end else if (sent_cmd == regs[REG_MODEL]) begin
          if (rx[0]) begin
            model_id    = rx[3:1];
            next_id     = rx[6:4];
            chained     = rx[7];
            linked      = 1'b1;
            delay_cnt   = INIT_DELAY;
            queued_cmd  = regs[REG_INQUIRY];
            queue_valid = 1'b1;
          end else begin
            ev = EV_REINIT;
            restart_link();
          end
        end else if (sent_cmd == regs[REG_TEST]) begin
          if (rx == regs[REG_ACK]) begin
            test = TEST_PASS;
          end else if (rx == regs[REG_NACK]) begin
            test = TEST_FAIL;
          end else begin
            ev = EV_REINIT;
            restart_link();
          end
        end else begin
          ev = EV_UNKNOWN;
        end
      end
      push_res(sv, sb, tr, 1'b0, 8'h00, 1'b1, test, ev);
    endfunction

    function void cmp(string name, logic [7:0] exp_v, logic [7:0] act_v);
      if (exp_v !== act_v) begin
        $error("%s: expected %0h, actual %0h", name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_result(res_t got);
      res_t e;
      if (expected_q.size() == 0) begin
        $error("result transaction with no event pending: %0h", got);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      cmp("send_valid", e.send_valid, got.send_valid);
      cmp("send_byte", e.send_byte, got.send_byte);
      cmp("to_receive", e.to_receive, got.to_receive);
      cmp("key_valid", e.key_valid, got.key_valid);
      cmp("key_code", e.key_code, got.key_code);
      cmp("last", e.last, got.last);
      cmp("test_result", e.test_result, got.test_result);
      cmp("kbd_model", e.kbd_model, got.kbd_model);
      cmp("kbd_next", e.kbd_next, got.kbd_next);
      cmp("next_chained", e.next_chained, got.next_chained);
      cmp("ready_res", e.ready_res, got.ready_res);
      cmp("event_res", e.event_res, got.event_res);
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst_n;
  logic       cfg_we;
  logic [2:0] cfg_index;
  logic [7:0] cfg_data;

  kplc_in_if  in_ch ();
  kplc_out_if out_ch ();

  keyboard_poll_link_controller u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  kbd_link_tracker tracker;

  int   items_sent = 0;
  int   burst_left = 1;
  logic in_held = 1'b0;
  int   rx_mode = 0;
  int   rx_left = 0;
  int   rx_phase = 0;

  always #5 clk = ~clk;

  // predict on every accepted event, check every accepted result
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) tracker.note_event(in_ch.cmd, in_ch.rx_byte);
      if (out_ch.valid && out_ch.ready) tracker.check_result(out_ch.data);
    end
  end

  // result side back-pressure in one of four randomly chosen modes
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 3);
      rx_left = $urandom_range(30, 200);
    end else begin
      rx_left--;
    end
    case (rx_mode)
      0: out_ch.ready <= 1'b1;
      1: out_ch.ready <= ($urandom_range(0, 1) == 0);
      2: out_ch.ready <= ($urandom_range(0, 4) == 0);
      default: begin
        rx_phase = (rx_phase + 1) % 8;
        out_ch.ready <= (rx_phase < 5);
      end
    endcase
  end

  initial begin
    int stall;
    stall = 0;
    while (stall < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we)
        stall = 0;
      else
        stall++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  // called at a falling edge, returns at a falling edge
  task automatic send(input logic c, input logic [7:0] b);
    int gap;
    in_ch.valid <= 1'b1;
    in_ch.cmd <= c;
    in_ch.rx_byte <= b;
    in_held = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    items_sent++;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        in_held = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
  endtask

  task automatic wait_idle();
    if (in_held) begin
      in_ch.valid <= 1'b0;
      in_held = 1'b0;
    end
    while (tracker.pending() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic set_reg(input logic [2:0] idx, input logic [7:0] val);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    tracker.set_reg(idx, val);
  endtask

  // rename codes so that the command just sent decodes another way
  task automatic retarget(input int kind);
    logic [7:0] s;
    s = tracker.sent_cmd;
    case (kind)
      AIM_TEST: begin
        set_reg(REG_INQUIRY, s ^ 8'h01);
        set_reg(REG_INSTANT, s ^ 8'h02);
        set_reg(REG_MODEL, s ^ 8'h03);
        set_reg(REG_TEST, s);
      end
      AIM_INSTANT: begin
        set_reg(REG_INQUIRY, s ^ 8'h01);
        set_reg(REG_INSTANT, s);
      end
      default: begin
        set_reg(REG_INQUIRY, s ^ 8'h01);
        set_reg(REG_INSTANT, s ^ 8'h02);
        set_reg(REG_MODEL, s ^ 8'h03);
        set_reg(REG_TEST, s ^ 8'h04);
      end
    endcase
  endtask

  function automatic logic [7:0] pick_reply();
    logic [7:0] s;
    logic [7:0] r;
    int roll;
    s = tracker.sent_cmd;
    r = 8'($urandom);
    roll = $urandom_range(0, 99);
    if (s == tracker.regs[REG_INQUIRY] || s == tracker.regs[REG_INSTANT]) begin
      if (roll < 25) r = tracker.regs[REG_NULL];
      else if (roll < 45) r = {r[7], CAPS_KEY, r[0]};
    end else if (s == tracker.regs[REG_MODEL]) begin
      r[0] = (roll < 70);
    end else if (s == tracker.regs[REG_TEST]) begin
      if (roll < 35) r = tracker.regs[REG_ACK];
      else if (roll < 70) r = tracker.regs[REG_NACK];
    end
    return r;
  endfunction

  task automatic run_session();
    int roll;
    int n;
    int bound;
    int lim;
    roll = $urandom_range(0, 99);
    lim = tracker.regs[REG_TIMEOUT];
    if (roll < 80) begin
      // ticks until the queued command goes out, then turnaround and reply
      bound = ((lim < 60) ? lim : 60) + 8;
      n = 0;
      do begin
        send(CMD_TICK, 8'($urandom));
        n++;
      end while (!tracker.sent_now && n < bound);
      if (tracker.sent_now && lim <= 60 && $urandom_range(0, 99) < 15)
        retarget($urandom_range(AIM_TEST, AIM_OTHER));
      send(CMD_IRQ, 8'($urandom));
      n = $urandom_range(0, 4);
      if (n > 2) n = 0;
      repeat (n) send(CMD_TICK, 8'($urandom));
      send(CMD_IRQ, pick_reply());
      if ($urandom_range(0, 9) == 0) send(CMD_IRQ, 8'($urandom));
    end else if (roll < 92 || lim > 30) begin
      repeat ($urandom_range(1, 6)) send(1'($urandom_range(0, 1)), 8'($urandom));
    end else begin
      // no replies for many timeouts in a row, short timeouts end in link loss
      n = $urandom_range(1, 12) * (lim + 1);
      if (n > LONG_RUN_MAX) n = LONG_RUN_MAX;
      repeat (n) send(CMD_TICK, 8'($urandom));
    end
  endtask

  task automatic configure(input int p);
    logic [7:0] v [8];
    int i;
    for (i = 0; i < 8; i++) v[i] = 8'($urandom);
    case (p)
      1: v[REG_TIMEOUT] = 8'd1;
      2: begin
        v[REG_INQUIRY] = 8'h00;
        v[REG_INSTANT] = 8'hff;
        v[REG_MODEL]   = 8'h01;
        v[REG_TEST]    = 8'hfe;
        v[REG_NULL]    = 8'h00;
        v[REG_ACK]     = 8'hff;
        v[REG_NACK]    = 8'h00;
        v[REG_TIMEOUT] = 8'hff;
      end
      3: begin
        // colliding codes exercise the match order
        v[REG_INSTANT] = v[REG_INQUIRY];
        v[REG_TEST]    = v[REG_MODEL];
        v[REG_NACK]    = v[REG_ACK];
        v[REG_TIMEOUT] = 8'($urandom_range(2, 10));
      end
      4: v[REG_TIMEOUT] = 8'($urandom_range(1, 8));
      5: v[REG_TIMEOUT] = 8'($urandom_range(20, 60));
      6: v[REG_TIMEOUT] = 8'($urandom_range(1, 255));
      default: begin
        v[REG_INQUIRY] = RST_INQUIRY;
        v[REG_INSTANT] = RST_INSTANT;
        v[REG_MODEL]   = RST_MODEL;
        v[REG_TEST]    = RST_TEST;
        v[REG_NULL]    = RST_NULL;
        v[REG_ACK]     = RST_ACK;
        v[REG_NACK]    = RST_NACK;
        v[REG_TIMEOUT] = RST_TIMEOUT;
      end
    endcase
    for (i = 0; i < 8; i++) set_reg(3'(i), v[i]);
  endtask

  task automatic directed();
    // interrupts straight after reset: turnaround, unknown reply, ignored
    send(CMD_IRQ, 8'h00);
    send(CMD_IRQ, 8'h00);
    send(CMD_IRQ, 8'hff);
    // send delay runs out, model query goes out
    repeat (3) begin
      send(CMD_TICK, 8'h00);
      send(CMD_TICK, 8'hff);
    end
    send(CMD_IRQ, 8'h55);
    send(CMD_IRQ, 8'hff);
    repeat (6) send(CMD_TICK, 8'h00);
    send(CMD_IRQ, 8'h00);
    send(CMD_IRQ, 8'h72);
    send(CMD_TICK, 8'h00);
    send(CMD_IRQ, 8'h00);
    send(CMD_IRQ, 8'hfe);
    send(CMD_TICK, 8'h00);
    send(CMD_IRQ, 8'h00);
    send(CMD_IRQ, RST_NULL);
  endtask

  initial begin
    int p;
    int start;
    tracker = new();
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.cmd = CMD_TICK;
    in_ch.rx_byte = '0;
    out_ch.ready = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    directed();
    // phase budgets are cumulative so one long run does not inflate the total
    start = items_sent;
    for (p = 0; p < NUM_PHASES; p++) begin
      if (p > 0) configure(p);
      while (items_sent < start + (p + 1) * RANDOM_ITEMS / NUM_PHASES) run_session();
    end

    wait_idle();
    repeat (10) @(posedge clk);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      if (tracker.pending() != 0) $error("%0d results never arrived", tracker.pending());
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+hdl
hdl/kplc_pkg.sv
hdl/kplc_if.sv
hdl/keyboard_poll_link_controller.sv
tb/tb_keyboard_poll_link_controller.sv
